// File: hdl/ils_pkg.sv
// Package for the irrigation line scheduler: sizes, modes and shared types.
// No dependencies.
package ils_pkg;
  localparam int NUM_LINES    = 16;
  localparam int QUEUE_DEPTH  = 16;
  localparam int ACTIVE_SLOTS = 2;
  localparam int LINE_W   = 4;
  localparam int ACC_W    = 20;
  localparam int REM_W    = 25;
  localparam int QCNT_W   = 5;
  localparam int QIDX_W   = 4;
  localparam int SCALE_W  = 12;
  localparam int DUR_W    = 16;
  localparam int PROD_W   = DUR_W + 2 * SCALE_W;
  localparam logic [SCALE_W-1:0] GSCALE_RST = 12'd256;

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2,
    MODE_IDLE = 2'd3
  } mode_t;
endpackage

// File: hdl/ils_mul.sv
// Bit-serial multiplier: duration * global_scale * line_scale >> 16.
// Depends on ils_pkg. One multiplier bit per cycle.
module ils_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ils_pkg::DUR_W-1:0]     dur,
  input  logic [ils_pkg::SCALE_W-1:0]   gscale,
  input  logic [ils_pkg::SCALE_W-1:0]   lscale,
  output logic                          busy,
  output logic [ils_pkg::REM_W-1:0]     result
);
  localparam int MB_W = 2 * ils_pkg::SCALE_W;
  logic [ils_pkg::PROD_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [MB_W-1:0] mplier_r, mplier_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [MB_W-1:0] sc_prod;

  // scale product is 12x12: narrow, done once at start
  assign sc_prod = MB_W'(gscale) * MB_W'(lscale);

  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = ils_pkg::PROD_W'(dur);
      mplier_nxt = sc_prod;
      cnt_nxt = 5'(MB_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt;
  end

  assign busy = busy_r;
  // full product fits in 40 bits, so the top result bit is always zero
  assign result = {1'b0, acc_r[ils_pkg::PROD_W-1:16]};
endmodule

// File: hdl/irrigation_line_scheduler.sv
// Top level of the irrigation line scheduler.
// Depends on ils_pkg and ils_mul.
//
// One item at a time. An item that queues a job waits on the bit-serial
// duration multiplier before its push; other items do not. On the final item
// the active slots at the queue head are served one step a cycle, with one
// shift of the queue per removed job, then 16 status beats follow, one per
// cycle while out_stall is low. No clearing pass after reset.
module irrigation_line_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_global_scale,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_line_index,
  input  logic [1:0]  in_mode,
  input  logic        in_has_program,
  input  logic [19:0] in_interval,
  input  logic [15:0] in_duration,
  input  logic [11:0] in_line_scale,
  input  logic [7:0]  in_elapsed,
  input  logic [16:0] in_now_seconds,
  input  logic [16:0] in_sunrise,
  input  logic [16:0] in_sunset,
  input  logic        in_sun_all_day,
  input  logic        in_last_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status_line,
  output logic        out_valve_on,
  output logic        out_changed,
  output logic        out_last_status
);
  localparam int NL = ils_pkg::NUM_LINES;
  localparam int QD = ils_pkg::QUEUE_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_JOB, S_MWAIT, S_PUSH, S_SERVE, S_SHIFT, S_FORCE, S_EMIT
  } state_t;

  state_t state_r;
  logic [ils_pkg::SCALE_W-1:0] gscale_r;
  logic [ils_pkg::ACC_W-1:0] accrual_r [NL];
  logic [1:0] modes_r [NL];
  logic [NL-1:0] valve_r, prev_r;
  logic [ils_pkg::LINE_W-1:0] qline_r [QD];
  logic [ils_pkg::REM_W-1:0] qrem_r [QD];
  logic [ils_pkg::QCNT_W-1:0] qcnt_r;

  // captured item
  logic [3:0] ln_r; logic [1:0] mode_r; logic prog_r; logic [19:0] intv_r;
  logic [15:0] dur_r; logic [11:0] lsc_r; logic [7:0] el_r; logic last_r;
  logic win_r;
  logic [ils_pkg::QIDX_W-1:0] slot_r, sh_r;
  logic [3:0] emit_r;
  logic out_valid_r, out_last_r, out_on_r, out_chg_r;
  logic [3:0] out_line_r;

  logic mul_start, mul_busy;
  logic [ils_pkg::REM_W-1:0] mres;

  ils_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .dur(dur_r),
    .gscale(gscale_r), .lscale(lsc_r), .busy(mul_busy), .result(mres)
  );

  // daylight window
  logic win;
  always_comb begin
    win = in_sun_all_day
      || (in_now_seconds > in_sunrise
          && (in_now_seconds < in_sunset || in_sunset < in_sunrise))
      || (in_now_seconds < in_sunrise && in_sunset < in_sunrise
          && in_sunset > in_now_seconds);
  end

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign mul_start = (state_r == S_JOB);

  logic [20:0] acc_sum;
  logic [19:0] acc_new;
  logic [ils_pkg::LINE_W-1:0] hl;
  assign acc_sum = {1'b0, accrual_r[ln_r]} + 21'(el_r);
  assign acc_new = (mode_r == ils_pkg::MODE_AUTO && win_r)
                 ? (acc_sum[20] ? 20'hFFFFF : acc_sum[19:0]) : accrual_r[ln_r];
  assign hl = qline_r[slot_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; gscale_r <= ils_pkg::GSCALE_RST; qcnt_r <= '0;
      valve_r <= '0; prev_r <= '0; out_valid_r <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        accrual_r[i] <= '0; modes_r[i] <= ils_pkg::MODE_AUTO;
      end
    end else begin
      if (cfg_we) gscale_r <= cfg_global_scale;
      case (state_r)
        S_IDLE: if (in_acc) begin
          ln_r <= in_line_index; mode_r <= in_mode; prog_r <= in_has_program;
          intv_r <= in_interval; dur_r <= in_duration; lsc_r <= in_line_scale;
          el_r <= in_elapsed; last_r <= in_last_line; win_r <= win;
          state_r <= S_ACC;
        end
        S_ACC: begin
          modes_r[ln_r] <= mode_r;
          if (!prog_r) begin
            accrual_r[ln_r] <= '0; state_r <= S_PUSH;
          end else if (intv_r != '0 && acc_new > intv_r) begin
            accrual_r[ln_r] <= '0;
            state_r <= (qcnt_r < 5'(QD)) ? S_JOB : S_PUSH;
          end else begin
            accrual_r[ln_r] <= acc_new; state_r <= S_PUSH;
          end
        end
        S_JOB: state_r <= S_MWAIT;
        S_MWAIT: if (!mul_busy) begin
          qline_r[qcnt_r[ils_pkg::QIDX_W-1:0]] <= ln_r;
          qrem_r[qcnt_r[ils_pkg::QIDX_W-1:0]] <= mres;
          qcnt_r <= qcnt_r + 5'd1;
          state_r <= S_PUSH;
        end
        // S_PUSH: end of item work; last item starts the service pass
        S_PUSH: begin
          if (last_r) begin
            valve_r <= '0; slot_r <= '0; state_r <= S_SERVE;
          end else state_r <= S_IDLE;
        end
        S_SERVE: begin
          if (5'(slot_r) < 5'(ils_pkg::ACTIVE_SLOTS) && 5'(slot_r) < qcnt_r) begin
            if (qrem_r[slot_r] == '0) begin
              valve_r[hl] <= 1'b0; sh_r <= slot_r; state_r <= S_SHIFT;
            end else begin
              valve_r[hl] <= 1'b1;
              qrem_r[slot_r] <= (qrem_r[slot_r] > 25'(el_r))
                              ? qrem_r[slot_r] - 25'(el_r) : '0;
              slot_r <= slot_r + 1'b1;
            end
          end else state_r <= S_FORCE;
        end
        // one entry moves up per cycle
        S_SHIFT: begin
          if (5'(sh_r) + 5'd1 < qcnt_r && 5'(sh_r) + 5'd1 < 5'(QD)) begin
            qline_r[sh_r] <= qline_r[sh_r + 1'b1];
            qrem_r[sh_r] <= qrem_r[sh_r + 1'b1];
            sh_r <= sh_r + 1'b1;
          end else begin
            qcnt_r <= qcnt_r - 5'd1; state_r <= S_SERVE;
          end
        end
        S_FORCE: begin
          for (int i = 0; i < NL; i++) begin
            if (modes_r[i] == ils_pkg::MODE_ON) valve_r[i] <= 1'b1;
            if (modes_r[i] == ils_pkg::MODE_OFF) valve_r[i] <= 1'b0;
          end
          emit_r <= '0; state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1; out_line_r <= emit_r;
            out_on_r <= valve_r[emit_r];
            out_chg_r <= valve_r[emit_r] ^ prev_r[emit_r];
            out_last_r <= (emit_r == 4'(NL - 1));
            prev_r[emit_r] <= valve_r[emit_r];
            emit_r <= emit_r + 4'd1;
            if (emit_r == 4'(NL - 1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && !out_stall && !(state_r == S_EMIT)) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status_line = out_line_r;
  assign out_valve_on = out_on_r;
  assign out_changed = out_chg_r;
  assign out_last_status = out_last_r;

`ifndef SYNTH
  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 5'(QD)) else $error("queue count overflow");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> in_stall) else $error("input taken during emit");
  a_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy |-> state_r == S_MWAIT) else $error("multiplier busy off job");
`endif
endmodule
